// ===== src/cqe_pkg.sv =====
// Shared types, codes and defaults of the circular queue engine.
`default_nettype none
package cqe_pkg;

	// Built ring depth and field widths.
	localparam int DEPTH_DEF = 64;
	localparam int CAP_W     = 7;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int DATA_W    = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// Operation codes of an input request.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT  = 2'd0,
		FN_DELETE  = 2'd1,
		FN_DISPLAY = 2'd2
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    push;
		logic    pop;
		logic    disp_start;
		logic    walk_next;
		logic    load_code;
		logic    load_mem;
		status_t code;
	} cqe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic more;
	} cqe_stat_t;

endpackage
`default_nettype wire

// ===== src/cqe_in_if.sv =====
// Input request channel of the circular queue engine.
`default_nettype none
interface cqe_in_if;
	logic                                valid;
	logic                                ready;
	logic        [cqe_pkg::FUNC_W-1:0]   func;
	logic signed [cqe_pkg::DATA_W-1:0]   push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink   (input valid, input func, input push_value, output ready);
endinterface
`default_nettype wire

// ===== src/cqe_out_if.sv =====
// Result channel of the circular queue engine.
`default_nettype none
interface cqe_out_if;
	logic                                valid;
	logic                                ready;
	logic        [cqe_pkg::STATUS_W-1:0] status;
	logic signed [cqe_pkg::DATA_W-1:0]   out_value;
	logic                                last;

	modport source (output valid, output status, output out_value, output last, input ready);
	modport sink   (input valid, input status, input out_value, input last, output ready);
endinterface
`default_nettype wire

// ===== src/cqe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/cqe_ctrl.sv =====
// Controller state machine of the circular queue engine.
`default_nettype none
module cqe_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cqe_pkg::FUNC_W-1:0]   in_func,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	input  wire cqe_pkg::cqe_stat_t           stat,
	output cqe_pkg::cqe_cmd_t                 cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_SEND = 3'b100
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.code       = cqe_pkg::ST_OK;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_func)
						cqe_pkg::FN_INSERT: begin
							cmd.load_code = 1'b1;
							if (stat.full) begin
								cmd.code = cqe_pkg::ST_FULL;
							end else begin
								cmd.push = 1'b1;
							end
							state_d = S_SEND;
						end
						cqe_pkg::FN_DELETE: begin
							if (stat.empty) begin
								cmd.load_code = 1'b1;
								cmd.code      = cqe_pkg::ST_EMPTY;
								state_d       = S_SEND;
							end else begin
								cmd.pop = 1'b1;
								state_d = S_READ;
							end
						end
						cqe_pkg::FN_DISPLAY: begin
							if (stat.empty) begin
								cmd.load_code = 1'b1;
								cmd.code      = cqe_pkg::ST_EMPTY;
								state_d       = S_SEND;
							end else begin
								cmd.disp_start = 1'b1;
								state_d        = S_READ;
							end
						end
						default: begin
							// The unused operation code is dropped without a result.
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.load_mem = 1'b1;
				state_d      = S_SEND;
			end
			S_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.more) begin
						cmd.walk_next = 1'b1;
						state_d       = S_READ;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/cqe_dp.sv =====
// Datapath of the circular queue engine: ring pointers, slot RAM and result register.
`default_nettype none
module cqe_dp #(
	parameter int DEPTH = cqe_pkg::DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic        [cqe_pkg::CAP_W-1:0]    cfg_wdata,
	input  wire logic signed [cqe_pkg::DATA_W-1:0]   push_value,
	input  wire cqe_pkg::cqe_cmd_t                   cmd,
	output cqe_pkg::cqe_stat_t                       stat,
	output logic             [cqe_pkg::STATUS_W-1:0] status,
	output logic signed      [cqe_pkg::DATA_W-1:0]   out_value,
	output logic                                     last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > cqe_pkg::CAP_W) ? CW : cqe_pkg::CAP_W;

	logic [cqe_pkg::CAP_W-1:0]  cap_q;
	logic [IW-1:0]              head_q, tail_q, walk_q;
	logic [CW-1:0]              count_q, remain_q;
	logic [cqe_pkg::STATUS_W-1:0] status_q;
	logic [cqe_pkg::DATA_W-1:0] value_q;
	logic                       last_q;

	logic [EW-1:0]              cap_ext, eff_cap;
	logic [IW-1:0]              head_nxt, tail_nxt, walk_nxt;
	logic [IW-1:0]              rd_addr;
	logic                       rd_en;
	logic [cqe_pkg::DATA_W-1:0] rd_data;

	// Capacity in use: zero counts as one, anything above the ring depth as the depth.
	assign cap_ext = EW'(cap_q);
	always_comb begin
		priority if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(DEPTH)) begin
			eff_cap = EW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// Pointer advance with wrap at the capacity in use.
	always_comb begin
		head_nxt = ((EW'(head_q) + EW'(1)) >= eff_cap) ? '0 : head_q + IW'(1);
		tail_nxt = ((EW'(tail_q) + EW'(1)) >= eff_cap) ? '0 : tail_q + IW'(1);
		walk_nxt = ((EW'(walk_q) + EW'(1)) >= eff_cap) ? '0 : walk_q + IW'(1);
	end

	// Status toward the controller.
	assign stat.full  = EW'(count_q) >= eff_cap;
	assign stat.empty = (count_q == '0);
	assign stat.more  = ~last_q;

	// Ring pointers, fill count and display walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= cqe_pkg::CAP_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			walk_q   <= '0;
			remain_q <= '0;
		end else if (cfg_we) begin
			// A capacity write empties the queue.
			cap_q   <= cfg_wdata;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CW'(1);
			end
			if (cmd.pop) begin
				head_q   <= head_nxt;
				count_q  <= count_q - CW'(1);
				remain_q <= CW'(1);
			end
			if (cmd.disp_start) begin
				walk_q   <= head_nxt;
				remain_q <= count_q;
			end
			if (cmd.walk_next) begin
				walk_q   <= walk_nxt;
				remain_q <= remain_q - CW'(1);
			end
		end
	end

	// Slot RAM read address: the head for a delete or the first listed word, the walk pointer for later words.
	assign rd_en   = cmd.pop | cmd.disp_start | cmd.walk_next;
	assign rd_addr = cmd.walk_next ? walk_q : head_q;

	cqe_ram #(
		.WIDTH (cqe_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (push_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Last flag of the held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
		end else if (cmd.load_code) begin
			last_q <= 1'b1;
		end else if (cmd.load_mem) begin
			last_q <= (remain_q == CW'(1));
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.load_code) begin
			status_q <= cmd.code;
			value_q  <= '0;
		end else if (cmd.load_mem) begin
			status_q <= cqe_pkg::ST_OK;
			value_q  <= rd_data;
		end
	end

	assign status    = status_q;
	assign out_value = value_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== src/circular_queue_engine_core.sv =====
// Circular queue engine: a ring-buffer FIFO of signed words with insert, delete and display.
// An insert result is offered in the cycle after its request is accepted. A delete result
// that carries a word passes the slot RAM read, then the result register; a display lists
// its words one at a time the same way. Only one request is handled at a time; the next one
// is accepted the cycle after the last result is taken.
// Reset empties the queue and sets the capacity to 64; the slot RAM is not cleared.
`default_nettype none
module circular_queue_engine_core #(
	parameter int DEPTH = cqe_pkg::DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [cqe_pkg::CAP_W-1:0] cfg_wdata,
	cqe_in_if.sink                         in_ch,
	cqe_out_if.source                      out_ch
);

	cqe_pkg::cqe_cmd_t  cmd;
	cqe_pkg::cqe_stat_t stat;

	// Request sequencing.
	cqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_func   (in_ch.func),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queue storage and result register.
	cqe_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push_value (in_ch.push_value),
		.cmd        (cmd),
		.stat       (stat),
		.status     (out_ch.status),
		.out_value  (out_ch.out_value),
		.last       (out_ch.last)
	);

endmodule
`default_nettype wire
